>>> rtl/core/abcc_pkg.sv
// Package for the analog button click classifier.
// Types, constants and register codes shared by all files; no dependencies.
`timescale 1ns / 1ps

package abcc_pkg;

  localparam int unsigned LaneCount  = 6;
  localparam int unsigned MaxLanes   = 6;
  localparam int unsigned ScanLanes  = (LaneCount < MaxLanes) ? LaneCount : MaxLanes;
  localparam int unsigned SampleW    = 8;
  localparam int unsigned CountW     = 8;
  localparam int unsigned ButtonW    = 3;
  localparam int unsigned MapW       = MaxLanes * ButtonW;
  localparam int unsigned CfgIndexW  = 3;
  localparam int unsigned CfgDataW   = MapW;

  localparam logic [CountW-1:0] HoldMax = 8'd255;

  localparam logic [SampleW-1:0] ThresholdReset = 8'd100;
  localparam logic [CountW-1:0]  DebounceReset  = 8'd4;
  localparam logic [CountW-1:0]  LongReset      = 8'd100;
  localparam logic [MapW-1:0]    MapReset       = 18'd71526;

  typedef enum logic [CfgIndexW-1:0] {
    CfgThreshold = 3'd0,
    CfgDebounce  = 3'd1,
    CfgLong      = 3'd2,
    CfgLaneMap   = 3'd3
  } cfg_index_e;

  typedef enum logic [1:0] {
    EdgeNone    = 2'd0,
    EdgePress   = 2'd1,
    EdgeRelease = 2'd2
  } edge_e;

  typedef enum logic [1:0] {
    ClickNone       = 2'd0,
    ClickShortPress = 2'd1,
    ClickShort      = 2'd2,
    ClickLong       = 2'd3
  } click_e;

  typedef struct packed {
    logic [SampleW-1:0] threshold;
    logic [CountW-1:0]  debounce;
    logic [CountW-1:0]  long_ticks;
    logic [MapW-1:0]    lane_map;
  } cfg_t;

  typedef struct packed {
    logic [ButtonW-1:0] button;
    edge_e              edge_kind;
    click_e             click;
  } result_t;

endpackage

>>> rtl/core/abcc_lane_decode.sv
// Lane decode: threshold compare per lane, single-press check, button map lookup.
// Depends on abcc_pkg.
`timescale 1ns / 1ps

module abcc_lane_decode (
  input  logic [abcc_pkg::SampleW-1:0] samples_i [abcc_pkg::MaxLanes],
  input  logic [abcc_pkg::SampleW-1:0] threshold_i,
  input  logic [abcc_pkg::MapW-1:0]    lane_map_i,
  output logic [abcc_pkg::ButtonW-1:0] button_o
);

  logic [abcc_pkg::MaxLanes-1:0] pressed;
  logic [abcc_pkg::ButtonW-1:0]  mapped;

  always_comb begin
    pressed = '0;
    mapped  = '0;
    for (int unsigned i = 0; i < abcc_pkg::MaxLanes; i++) begin
      pressed[i] = (i < abcc_pkg::ScanLanes) && (samples_i[i] < threshold_i);
      if (pressed[i]) begin
        mapped = mapped | lane_map_i[i*abcc_pkg::ButtonW +: abcc_pkg::ButtonW];
      end
    end
    // only a single pressed lane selects a button
    button_o = $onehot(pressed) ? mapped : '0;
  end

endmodule

>>> rtl/core/abcc_classifier.sv
// Hold counter, captured count and click classification per scan tick.
// Depends on abcc_pkg.
`timescale 1ns / 1ps

module abcc_classifier (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         step_i,
  input  logic [abcc_pkg::ButtonW-1:0] button_i,
  input  abcc_pkg::cfg_t               cfg_i,
  output abcc_pkg::result_t            result_o
);

  logic [abcc_pkg::ButtonW-1:0] last_q, last_d;
  logic [abcc_pkg::CountW-1:0]  hold_q, hold_d;
  logic [abcc_pkg::CountW-1:0]  capt_q, capt_d;

  always_comb begin
    capt_d = ((hold_q == '0) || (hold_q > cfg_i.debounce)) ? hold_q : capt_q;
    if (last_q == button_i) begin
      hold_d = (hold_q != abcc_pkg::HoldMax) ? hold_q + 1'b1 : hold_q;
    end else begin
      hold_d = '0;
    end
    last_d = button_i;

    result_o.button    = button_i;
    result_o.edge_kind = abcc_pkg::EdgeNone;
    result_o.click     = abcc_pkg::ClickNone;
    if ((last_q != '0) && (button_i == '0)) begin
      result_o.edge_kind = abcc_pkg::EdgeRelease;
      result_o.button    = last_q;
    end else if ((last_q == '0) && (button_i != '0)) begin
      result_o.edge_kind = abcc_pkg::EdgePress;
    end

    if (result_o.edge_kind == abcc_pkg::EdgeRelease) begin
      if ((capt_d > cfg_i.debounce) && (capt_d < cfg_i.long_ticks)) begin
        result_o.click = abcc_pkg::ClickShort;
      end else if (capt_d >= cfg_i.long_ticks) begin
        result_o.click = abcc_pkg::ClickLong;
      end
    end else if (hold_d == cfg_i.debounce) begin
      result_o.click = abcc_pkg::ClickShortPress;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
      hold_q <= '0;
      capt_q <= '0;
    end else if (step_i) begin
      last_q <= last_d;
      hold_q <= hold_d;
      capt_q <= capt_d;
    end
  end

endmodule

>>> rtl/core/analog_button_click_classifier.sv
// Top level: config registers, sample input register, result output register.
// Depends on abcc_pkg, abcc_lane_decode and abcc_classifier.
`timescale 1ns / 1ps

// One result per scan tick, one tick per clock while the output side takes
// results. A transfer on the input lands in the sample register; when the
// result register is free the tick is decoded, the hold counter updated and
// the result register loaded, so a new tick can enter while the last one
// moves on. Output stall backs up through the sample register to
// in_stall_o. Configuration registers are written through cfg_we_i /
// cfg_index_i / cfg_wdata_i (unknown indexes ignored); the user must write
// them only while no tick is in flight, as the block does not enforce this.
module analog_button_click_classifier (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [abcc_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [abcc_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [abcc_pkg::SampleW-1:0]   sample_0_i,
  input  logic [abcc_pkg::SampleW-1:0]   sample_1_i,
  input  logic [abcc_pkg::SampleW-1:0]   sample_2_i,
  input  logic [abcc_pkg::SampleW-1:0]   sample_3_i,
  input  logic [abcc_pkg::SampleW-1:0]   sample_4_i,
  input  logic [abcc_pkg::SampleW-1:0]   sample_5_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [abcc_pkg::ButtonW-1:0]   button_number_o,
  output logic [1:0]                     edge_kind_o,
  output logic [1:0]                     click_class_o
);

  abcc_pkg::cfg_t    cfg_q;
  logic              s1_valid_q;
  logic [abcc_pkg::SampleW-1:0] s1_samp_q [abcc_pkg::MaxLanes];
  logic [abcc_pkg::SampleW-1:0] in_samp   [abcc_pkg::MaxLanes];
  logic              out_free;
  logic              s1_adv;
  logic              in_xfer;
  logic [abcc_pkg::ButtonW-1:0] cur_button;
  abcc_pkg::result_t res_d, res_q;
  logic              out_valid_q;

  assign in_samp[0] = sample_0_i;
  assign in_samp[1] = sample_1_i;
  assign in_samp[2] = sample_2_i;
  assign in_samp[3] = sample_3_i;
  assign in_samp[4] = sample_4_i;
  assign in_samp[5] = sample_5_i;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold  <= abcc_pkg::ThresholdReset;
      cfg_q.debounce   <= abcc_pkg::DebounceReset;
      cfg_q.long_ticks <= abcc_pkg::LongReset;
      cfg_q.lane_map   <= abcc_pkg::MapReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        abcc_pkg::CfgThreshold: cfg_q.threshold  <= cfg_wdata_i[abcc_pkg::SampleW-1:0];
        abcc_pkg::CfgDebounce:  cfg_q.debounce   <= cfg_wdata_i[abcc_pkg::CountW-1:0];
        abcc_pkg::CfgLong:      cfg_q.long_ticks <= cfg_wdata_i[abcc_pkg::CountW-1:0];
        abcc_pkg::CfgLaneMap:   cfg_q.lane_map   <= cfg_wdata_i[abcc_pkg::MapW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_samp_q <= in_samp;
    end
  end

  abcc_lane_decode u_decode (
    .samples_i   (s1_samp_q),
    .threshold_i (cfg_q.threshold),
    .lane_map_i  (cfg_q.lane_map),
    .button_o    (cur_button)
  );

  abcc_classifier u_classifier (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (s1_adv),
    .button_i (cur_button),
    .cfg_i    (cfg_q),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign button_number_o = res_q.button;
  assign edge_kind_o     = res_q.edge_kind;
  assign click_class_o   = res_q.click;

endmodule

>>> rtl/core/abcc_checker.sv
// Port-level checks for the click classifier, bound to the top level.
// Depends on abcc_pkg and analog_button_click_classifier.
`timescale 1ns / 1ps

module abcc_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [abcc_pkg::ButtonW-1:0] button_number_o,
  input logic [1:0]                   edge_kind_o,
  input logic [1:0]                   click_class_o
);

  // short or long click only on a release
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (click_class_o == abcc_pkg::ClickShort ||
                    click_class_o == abcc_pkg::ClickLong)
    |-> edge_kind_o == abcc_pkg::EdgeRelease)
    else $error("click class without release");

  // any transition names a real button
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (edge_kind_o == abcc_pkg::EdgePress ||
                    edge_kind_o == abcc_pkg::EdgeRelease)
    |-> button_number_o != '0)
    else $error("transition with button zero");

  // a release reports no short press
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && edge_kind_o == abcc_pkg::EdgeRelease
    |-> click_class_o != abcc_pkg::ClickShortPress)
    else $error("short press on release");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i
    |=> out_valid_o && $stable(button_number_o) && $stable(edge_kind_o)
        && $stable(click_class_o))
    else $error("stalled result changed");

endmodule

bind analog_button_click_classifier abcc_checker u_abcc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .button_number_o (button_number_o),
  .edge_kind_o     (edge_kind_o),
  .click_class_o   (click_class_o)
);

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for analog_button_click_classifier: directed then random scan ticks
// under several register settings, results checked by a click-predicting scoreboard.
// Depends on abcc_pkg and the classifier RTL.

module tb_top;

  localparam int unsigned QuietLimit  = 5000;
  localparam int unsigned DrainCycles = 4;
  localparam int unsigned MaxReports  = 40;
  localparam int unsigned SatHold     = 258;
  localparam logic [abcc_pkg::CfgIndexW-1:0] CfgUnusedLow = 3'd4;

  typedef logic [abcc_pkg::MaxLanes-1:0][abcc_pkg::SampleW-1:0] lanes_t;

  class click_scoreboard;
    abcc_pkg::cfg_t               cfg;
    logic [abcc_pkg::ButtonW-1:0] last_button;
    logic [abcc_pkg::CountW-1:0]  hold_count;
    logic [abcc_pkg::CountW-1:0]  captured_count;
    abcc_pkg::result_t            click_q[$];
    int unsigned                  errors;

    function new();
      cfg = '{threshold: abcc_pkg::ThresholdReset, debounce: abcc_pkg::DebounceReset,
              long_ticks: abcc_pkg::LongReset, lane_map: abcc_pkg::MapReset};
      last_button    = '0;
      hold_count     = '0;
      captured_count = '0;
      errors         = 0;
    endfunction

    function void write_reg(logic [abcc_pkg::CfgIndexW-1:0] idx,
                            logic [abcc_pkg::CfgDataW-1:0] data);
      unique case (idx)
        abcc_pkg::CfgThreshold: cfg.threshold  = data[abcc_pkg::SampleW-1:0];
        abcc_pkg::CfgDebounce:  cfg.debounce   = data[abcc_pkg::CountW-1:0];
        abcc_pkg::CfgLong:      cfg.long_ticks = data[abcc_pkg::CountW-1:0];
        abcc_pkg::CfgLaneMap:   cfg.lane_map   = data[abcc_pkg::MapW-1:0];
        default: ;
      endcase
    endfunction

    function void note_tick(lanes_t lanes);
      int unsigned                  hits;
      int unsigned                  hit_lane;
      logic [abcc_pkg::ButtonW-1:0] current;
      abcc_pkg::result_t            res;
      hits     = 0;
      hit_lane = 0;
      for (int unsigned i = 0; i < abcc_pkg::ScanLanes; i++) begin
        if (lanes[i] < cfg.threshold) begin
          if (hits == 0) hit_lane = i;
          hits++;
        end
      end
      current = (hits == 1) ?
                cfg.lane_map[hit_lane*abcc_pkg::ButtonW +: abcc_pkg::ButtonW] : '0;
      if (hold_count == '0 || hold_count > cfg.debounce) captured_count = hold_count;
      if (last_button == current) begin
        if (hold_count != abcc_pkg::HoldMax) hold_count++;
      end else begin
        hold_count = '0;
      end
      if (last_button != '0 && current == '0) begin
        res.edge_kind = abcc_pkg::EdgeRelease;
        res.button    = last_button;
      end else if (last_button == '0 && current != '0) begin
        res.edge_kind = abcc_pkg::EdgePress;
        res.button    = current;
      end else begin
        res.edge_kind = abcc_pkg::EdgeNone;
        res.button    = current;
      end
      res.click = abcc_pkg::ClickNone;
      if (res.edge_kind == abcc_pkg::EdgeRelease) begin
        if (captured_count > cfg.debounce && captured_count < cfg.long_ticks) begin
          res.click = abcc_pkg::ClickShort;
        end else if (captured_count >= cfg.long_ticks) begin
          res.click = abcc_pkg::ClickLong;
        end
      end else if (hold_count == cfg.debounce) begin
        res.click = abcc_pkg::ClickShortPress;
      end
      last_button = current;
      click_q.push_back(res);
    endfunction

    function void report(string field, logic [7:0] exp_v, logic [7:0] got_v);
      errors++;
      if (errors <= MaxReports) begin
        $display("%0t: %s expected %0d got %0d", $time, field, exp_v, got_v);
      end
    endfunction

    function void check_result(abcc_pkg::result_t got);
      abcc_pkg::result_t exp_r;
      if (click_q.size() == 0) begin
        errors++;
        if (errors <= MaxReports) begin
          $display("%0t: unexpected transfer, expected none got button %0d edge %0d click %0d",
                   $time, got.button, got.edge_kind, got.click);
        end
        return;
      end
      exp_r = click_q.pop_front();
      if (got.button !== exp_r.button) report("button_number", 8'(exp_r.button), 8'(got.button));
      if (got.edge_kind !== exp_r.edge_kind) begin
        report("edge_kind", 8'(exp_r.edge_kind), 8'(got.edge_kind));
      end
      if (got.click !== exp_r.click) report("click_class", 8'(exp_r.click), 8'(got.click));
    endfunction

    function int unsigned pending();
      return click_q.size();
    endfunction
  endclass

  logic                           clk       = 1'b0;
  logic                           rst_n     = 1'b0;
  logic                           cfg_we    = 1'b0;
  logic [abcc_pkg::CfgIndexW-1:0] cfg_index = '0;
  logic [abcc_pkg::CfgDataW-1:0]  cfg_wdata = '0;
  logic                           in_valid  = 1'b0;
  lanes_t                         samples   = '0;
  logic                           out_stall = 1'b0;
  logic                           in_stall;
  logic                           out_valid;
  logic [abcc_pkg::ButtonW-1:0]   button;
  logic [1:0]                     edge_kind;
  logic [1:0]                     click_class;

  click_scoreboard sb;
  int unsigned     tx_idle_pct = 0;
  int unsigned     rx_idle_pct = 0;
  int unsigned     sent = 0;

  analog_button_click_classifier i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .sample_0_i      (samples[0]),
    .sample_1_i      (samples[1]),
    .sample_2_i      (samples[2]),
    .sample_3_i      (samples[3]),
    .sample_4_i      (samples[4]),
    .sample_5_i      (samples[5]),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .button_number_o (button),
    .edge_kind_o     (edge_kind),
    .click_class_o   (click_class)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99, 0) < rx_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_tick(samples);
    if (rst_n && out_valid && !out_stall) sb.check_result({button, edge_kind, click_class});
  end

  function automatic lanes_t make_lanes(logic [abcc_pkg::MaxLanes-1:0] mask);
    lanes_t l;
    for (int i = 0; i < abcc_pkg::MaxLanes; i++) begin
      if (mask[i] && sb.cfg.threshold != '0) begin
        l[i] = 8'($urandom_range(int'(sb.cfg.threshold) - 1, 0));
      end else begin
        l[i] = 8'($urandom_range(255, int'(sb.cfg.threshold)));
      end
    end
    return l;
  endfunction

  function automatic lanes_t one_low(int unsigned lane, logic [abcc_pkg::SampleW-1:0] level);
    lanes_t l;
    l       = '1;
    l[lane] = level;
    return l;
  endfunction

  task automatic send_tick(lanes_t lanes);
    if (sent < 200) begin
      tx_idle_pct = 28;
      rx_idle_pct = 80;
    end else if (sent < 400) begin
      tx_idle_pct = 80;
      rx_idle_pct = 28;
    end else begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
    while ($urandom_range(99, 0) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    samples  <= lanes;
    do @(posedge clk); while (in_stall);
    sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic write_reg(logic [abcc_pkg::CfgIndexW-1:0] idx,
                           logic [abcc_pkg::CfgDataW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    sb.write_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic program_regs(int unsigned thr, int unsigned deb, int unsigned lng,
                              int unsigned map);
    write_reg(CfgUnusedLow + abcc_pkg::CfgIndexW'($urandom_range(3, 0)),
              abcc_pkg::CfgDataW'($urandom()));
    write_reg(abcc_pkg::CfgThreshold, abcc_pkg::CfgDataW'(thr));
    write_reg(abcc_pkg::CfgDebounce, abcc_pkg::CfgDataW'(deb));
    write_reg(abcc_pkg::CfgLong, abcc_pkg::CfgDataW'(lng));
    write_reg(abcc_pkg::CfgLaneMap, abcc_pkg::CfgDataW'(map));
    cfg_we <= 1'b0;
  endtask

  // Mostly clean press/hold/release sequences, some multi-lane and raw noise.
  task automatic run_episode(int unsigned hold_max);
    int unsigned pick;
    int unsigned lane;
    int unsigned len;
    pick = $urandom_range(99, 0);
    len  = $urandom_range(hold_max, 1);
    if (pick < 70) begin
      lane = $urandom_range(abcc_pkg::MaxLanes - 1, 0);
      repeat (len) send_tick(make_lanes(abcc_pkg::MaxLanes'(1 << lane)));
      if ($urandom_range(3, 0) != 0) repeat ($urandom_range(3, 1)) send_tick(make_lanes('0));
    end else if (pick < 85) begin
      repeat ($urandom_range(3, 1)) send_tick(make_lanes(abcc_pkg::MaxLanes'($urandom())));
    end else begin
      repeat ($urandom_range(3, 1)) send_tick(48'({$urandom(), $urandom()}));
    end
  endtask

  task automatic run_phase(int unsigned thr, int unsigned deb, int unsigned lng,
                           int unsigned map, int unsigned budget, int unsigned hold_max);
    int unsigned start;
    drain();
    program_regs(thr, deb, lng, map);
    start = sent;
    while (sent - start < budget) run_episode(hold_max);
  endtask

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    sb = new();
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: none, all lanes, each lane, short click, threshold boundary
    send_tick('1);
    send_tick('0);
    for (int unsigned lane = 0; lane < abcc_pkg::MaxLanes; lane++) begin
      send_tick(one_low(lane, 8'h00));
    end
    send_tick('1);
    repeat (6) send_tick(one_low(4, 8'h63));
    send_tick('1);
    send_tick(one_low(2, abcc_pkg::ThresholdReset));
    send_tick(one_low(2, abcc_pkg::ThresholdReset - 8'd1));
    send_tick('1);

    run_phase(100, 2, 6, abcc_pkg::MapReset, 40, 10);
    run_phase(200, 0, 0, 18'o123450, 40, 5);
    run_phase(255, 255, 255, 18'o777777, 0, 1);
    repeat (SatHold) send_tick(make_lanes(6'b000100));
    send_tick(make_lanes('0));
    repeat (2) begin
      run_phase($urandom_range(255, 1), $urandom_range(6, 0), $urandom_range(12, 0),
                $urandom_range(18'h3FFFF, 0), 30, 14);
    end
    run_phase(1, 3, 3, $urandom_range(18'h3FFFF, 0), 20, 6);
    run_phase(128, 9, 4, abcc_pkg::MapReset, 20, 14);
    run_phase(0, 0, 0, 0, 15, 3);

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/abcc_pkg.sv
rtl/core/abcc_lane_decode.sv
rtl/core/abcc_classifier.sv
rtl/core/analog_button_click_classifier.sv
rtl/core/abcc_checker.sv
dv/tb_top.sv
